// ===== rtl/core/particle_filter_resample_engine_macros.svh =====
// assertion macros for the particle filter resample engine
`ifndef PARTICLE_FILTER_RESAMPLE_ENGINE_MACROS_SVH
`define PARTICLE_FILTER_RESAMPLE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define PFRE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfre assertion failed");
`define PFRE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfre assertion failed");
`else
`define PFRE_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PFRE_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/pfre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pfre_pkg;
    localparam int MAX_PARTICLES = 256;
    localparam int NDIMS = 4;
    localparam int DIM = 4;
    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = IDX_W + 1;
    localparam int DIM_W = $clog2(NDIMS);
    localparam int POS_W = 32;
    localparam int WGT_W = 16;
    localparam int NZ_W = 16;
    localparam int CUM_W = 24;
    localparam int ACC_W = 57;
    localparam int DIV_STEP_W = $clog2(ACC_W);
    localparam int PTR_W = 48;
    localparam int VEC_W = NDIMS * POS_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_3 = 3'd4;

    localparam logic KIND_ESTIMATE = 1'b0;
    localparam logic KIND_DIFFUSED = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ESTIMATE = 2'd1,
        OP_RESAMPLE = 2'd2,
        OP_DIFFUSE = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_NZ_MUL, S_NZ_ADD,
        S_EST_RD, S_EST_MUL, S_EST_ACC, S_EST_END,
        S_DIV_GO, S_DIV_WAIT, S_EMIT,
        S_RS_INIT, S_CP_RD, S_CP_WR,
        S_RS_CRD, S_RS_MUL, S_RS_CMP, S_RS_WR
    } t_state;

    typedef logic [NDIMS-1:0][POS_W-1:0] t_vec;

    typedef struct packed {
        t_op op;
        logic [IDX_W-1:0] index;
        logic signed [POS_W-1:0] pos_0;
        logic signed [POS_W-1:0] pos_1;
        logic signed [POS_W-1:0] pos_2;
        logic signed [POS_W-1:0] pos_3;
        logic [WGT_W-1:0] weight;
        logic [WGT_W-1:0] start_frac;
        logic signed [NZ_W-1:0] noise_0;
        logic signed [NZ_W-1:0] noise_1;
        logic signed [NZ_W-1:0] noise_2;
        logic signed [NZ_W-1:0] noise_3;
    } t_in_word;

    typedef struct packed {
        logic kind;
        logic [IDX_W-1:0] out_index;
        logic signed [POS_W-1:0] out_0;
        logic signed [POS_W-1:0] out_1;
        logic signed [POS_W-1:0] out_2;
        logic signed [POS_W-1:0] out_3;
        logic degenerate;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic [ACC_W-1:0] dividend;
        logic [CUM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [ACC_W-1:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== rtl/core/pfre_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pfre_in_if;
    logic valid;
    logic ready;
    pfre_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pfre_out_if;
    logic valid;
    logic ready;
    pfre_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/particle_filter_resample_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  word                                   handshake
// i_in      in   op, index, pos, weight, frac, noise    valid/ready
// o_out     out  kind, out_index, out_0..3, degenerate  valid/ready
// i_cfg     in   register index and data                write enable
//
// load runs NZ_MUL, NZ_ADD; diffuse adds EMIT and the output register; one item at a time
// estimate runs EST_RD, EST_MUL, EST_ACC per particle, then 4 divisions (shared divider)
// resample copies with CP_RD, CP_WR per particle, or walks with RS_CRD, RS_MUL, RS_CMP per
// pointer advance and RS_WR per slot, bound by the single read port of each particle memory
// reset is synchronous; cumulative entries read as zero until written after reset
// a result waiting on o_out stalls only the next emitting item
`include "particle_filter_resample_engine_macros.svh"
module particle_filter_resample_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pfre_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pfre_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    pfre_in_if.sink                           i_in,
    pfre_out_if.source                        o_out
);
    import pfre_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [POS_W-1:0] r_sigma [NDIMS];
    logic [MAX_PARTICLES-1:0] r_cum_vld;
    logic [CUM_W-1:0] r_total;
    logic r_out_valid;
    t_out_word r_out;

    t_in_word r_req;
    t_out_word r_res;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_w;
    logic [DIM_W-1:0] r_d;
    logic [CUM_W-1:0] r_sum;
    logic [WGT_W-1:0] r_wgt;
    logic signed [ACC_W-1:0] r_acc [NDIMS];
    logic signed [48:0] r_prod [NDIMS];
    logic signed [48:0] r_nprod [NDIMS];
    logic signed [POS_W-1:0] r_base [NDIMS];
    logic [32:0] r_lhs;
    logic [PTR_W-1:0] r_ptr;

    logic [CNT_W-1:0] act_cnt;
    logic [IDX_W-1:0] last_idx;
    logic in_fire, idx_ok, out_free, advance;
    logic [CUM_W-1:0] n_run, cum_val;
    logic signed [NZ_W-1:0] noise_v [NDIMS];
    logic signed [POS_W-1:0] pos_v [NDIMS];
    t_vec nz_val;
    t_vec p_rdata_v, rs_rdata_v;
    logic [POS_W-1:0] div_val;
    logic signed [ACC_W-1:0] acc_sel;
    logic [ACC_W-1:0] mag;

    logic p_we, w_we, c_we, rs_we;
    logic [IDX_W-1:0] p_raddr;
    logic [VEC_W-1:0] p_rdata, rs_rdata;
    logic [WGT_W-1:0] w_rdata;
    logic [CUM_W-1:0] c_rdata;
    t_div_req div_req;
    t_div_rsp div_rsp;

    always_comb begin
        act_cnt = r_count;
        if (r_count == '0) begin
            act_cnt = CNT_W'(1);
        end else if (r_count > CNT_W'(MAX_PARTICLES)) begin
            act_cnt = CNT_W'(MAX_PARTICLES);
        end
        last_idx = IDX_W'(act_cnt - 1'b1);
        in_fire = i_in.valid & i_in.ready;
        idx_ok = {1'b0, i_in.data.index} < act_cnt;
        out_free = !r_out_valid || o_out.ready;
        n_run = r_sum + CUM_W'(r_wgt);
        cum_val = r_cum_vld[r_w] ? c_rdata : '0;
        advance = ({r_lhs, 16'b0} < {1'b0, r_ptr}) && (r_w != last_idx);
        noise_v[0] = r_req.noise_0;
        noise_v[1] = r_req.noise_1;
        noise_v[2] = r_req.noise_2;
        noise_v[3] = r_req.noise_3;
        pos_v[0] = r_req.pos_0;
        pos_v[1] = r_req.pos_1;
        pos_v[2] = r_req.pos_2;
        pos_v[3] = r_req.pos_3;
        p_rdata_v = p_rdata;
        rs_rdata_v = rs_rdata;
    end

    always_comb begin
        logic signed [48:0] t;
        logic signed [49:0] s;
        for (int d = 0; d < NDIMS; d++) begin
            t = (r_nprod[d] + 49'sd2048) >>> 12;
            s = 50'(r_base[d]) + 50'(t);
            if (d >= DIM) begin
                nz_val[d] = '0;
            end else if (s[49:31] == '0 || s[49:31] == '1) begin
                nz_val[d] = s[31:0];
            end else begin
                nz_val[d] = s[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end
    end

    always_comb begin
        acc_sel = r_acc[r_d];
        mag = acc_sel[ACC_W-1] ? ACC_W'(-acc_sel) : ACC_W'(acc_sel);
        div_req.start = (r_state == S_DIV_GO);
        div_req.dividend = mag + ACC_W'(r_total >> 1);
        div_req.divisor = r_total;
        if (div_rsp.quotient[ACC_W-1:31] != '0) begin
            div_val = acc_sel[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            div_val = acc_sel[ACC_W-1] ? -div_rsp.quotient[31:0] : div_rsp.quotient[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in.data.op)
                        OP_LOAD, OP_DIFFUSE: n_state = idx_ok ? S_NZ_MUL : S_IDLE;
                        OP_ESTIMATE: n_state = S_EST_RD;
                        OP_RESAMPLE: n_state = S_RS_INIT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_NZ_MUL: n_state = S_NZ_ADD;
            S_NZ_ADD: n_state = (r_req.op == OP_DIFFUSE) ? S_EMIT : S_IDLE;
            S_EST_RD: n_state = S_EST_MUL;
            S_EST_MUL: n_state = S_EST_ACC;
            S_EST_ACC: n_state = (r_i == last_idx) ? S_EST_END : S_EST_RD;
            S_EST_END: n_state = (r_sum == '0) ? S_EMIT : S_DIV_GO;
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_d == DIM_W'(NDIMS - 1)) ? S_EMIT : S_DIV_GO;
                end
            end
            S_EMIT: n_state = out_free ? S_IDLE : S_EMIT;
            S_RS_INIT: n_state = (r_total == '0) ? S_CP_RD : S_RS_CRD;
            S_CP_RD: n_state = S_CP_WR;
            S_CP_WR: n_state = (r_i == last_idx) ? S_IDLE : S_CP_RD;
            S_RS_CRD: n_state = S_RS_MUL;
            S_RS_MUL: n_state = S_RS_CMP;
            S_RS_CMP: n_state = advance ? S_RS_CRD : S_RS_WR;
            S_RS_WR: n_state = (r_i == last_idx) ? S_IDLE : S_RS_CRD;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        p_we = (r_state == S_NZ_ADD);
        w_we = (r_state == S_NZ_ADD) && (r_req.op == OP_LOAD);
        c_we = (r_state == S_EST_ACC);
        rs_we = (r_state == S_CP_WR) || (r_state == S_RS_WR);
        p_raddr = (r_state == S_RS_CMP) ? r_w : r_i;
    end

    pfre_ram #(.WIDTH(VEC_W), .DEPTH(MAX_PARTICLES)) u_particle_ram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(r_req.index), .i_wdata(nz_val),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    pfre_ram #(.WIDTH(WGT_W), .DEPTH(MAX_PARTICLES)) u_weight_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_req.index), .i_wdata(r_req.weight),
        .i_raddr(r_i), .o_rdata(w_rdata)
    );

    pfre_ram #(.WIDTH(CUM_W), .DEPTH(MAX_PARTICLES)) u_cum_ram (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(r_i), .i_wdata(n_run),
        .i_raddr(r_w), .o_rdata(c_rdata)
    );

    pfre_ram #(.WIDTH(VEC_W), .DEPTH(MAX_PARTICLES)) u_resampled_ram (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(r_i), .i_wdata(p_rdata),
        .i_raddr(i_in.data.index), .o_rdata(rs_rdata)
    );

    pfre_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CNT_W'(MAX_PARTICLES);
            for (int d = 0; d < NDIMS; d++) begin
                r_sigma[d] <= '0;
            end
            r_cum_vld <= '0;
            r_total <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_COUNT) begin
                    r_count <= i_cfg_data[CNT_W-1:0];
                end else if (i_cfg_idx >= REG_SIGMA_0 && i_cfg_idx <= REG_SIGMA_3) begin
                    r_sigma[DIM_W'(i_cfg_idx - REG_SIGMA_0)] <= i_cfg_data;
                end
            end
            if (r_state == S_EST_ACC) begin
                r_cum_vld[r_i] <= 1'b1;
            end
            if (r_state == S_EST_END) begin
                r_total <= r_sum;
                if (r_sum == '0) begin
                    r_cum_vld <= '0;
                end
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req <= i_in.data;
                r_i <= '0;
                r_w <= '0;
                r_d <= '0;
                r_sum <= '0;
                for (int d = 0; d < NDIMS; d++) begin
                    r_acc[d] <= '0;
                end
            end
            S_NZ_MUL: begin
                for (int d = 0; d < NDIMS; d++) begin
                    r_nprod[d] <= $signed({1'b0, r_sigma[d]}) * noise_v[d];
                    r_base[d] <= (r_req.op == OP_LOAD) ? pos_v[d] : rs_rdata_v[d];
                end
            end
            S_NZ_ADD: begin
                r_res <= {KIND_DIFFUSED, r_req.index,
                          nz_val[0], nz_val[1], nz_val[2], nz_val[3], 1'b0};
            end
            S_EST_MUL: begin
                r_wgt <= w_rdata;
                for (int d = 0; d < NDIMS; d++) begin
                    r_prod[d] <= $signed(p_rdata_v[d]) * $signed({1'b0, w_rdata});
                end
            end
            S_EST_ACC: begin
                r_sum <= n_run;
                r_i <= r_i + 1'b1;
                for (int d = 0; d < NDIMS; d++) begin
                    r_acc[d] <= r_acc[d] + ACC_W'(r_prod[d]);
                end
            end
            S_EST_END: begin
                r_res <= {KIND_ESTIMATE, {IDX_W{1'b0}}, {VEC_W{1'b0}}, (r_sum == '0)};
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    case (r_d)
                        2'd0: r_res.out_0 <= (DIM > 0) ? div_val : '0;
                        2'd1: r_res.out_1 <= (DIM > 1) ? div_val : '0;
                        2'd2: r_res.out_2 <= (DIM > 2) ? div_val : '0;
                        default: r_res.out_3 <= (DIM > 3) ? div_val : '0;
                    endcase
                    r_d <= r_d + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            S_RS_INIT: begin
                r_ptr <= PTR_W'(r_total) * PTR_W'(r_req.start_frac);
            end
            S_CP_WR: begin
                r_i <= r_i + 1'b1;
            end
            S_RS_MUL: begin
                r_lhs <= 33'(cum_val) * 33'(act_cnt);
            end
            S_RS_CMP: begin
                if (advance) begin
                    r_w <= r_w + 1'b1;
                end
            end
            S_RS_WR: begin
                r_i <= r_i + 1'b1;
                r_ptr <= r_ptr + PTR_W'({r_total, 16'b0});
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data = r_out;

    `PFRE_ASSERT_NEXT(a_est_starts, i_clk, i_rst_n, in_fire && i_in.data.op == OP_ESTIMATE, r_state == S_EST_RD)
    `PFRE_ASSERT_IMP(a_walk_bound, i_clk, i_rst_n, r_state == S_RS_CMP, {1'b0, r_w} < act_cnt)
    `PFRE_ASSERT_IMP(a_div_owned, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV_WAIT)
endmodule
`default_nettype wire

// ===== rtl/core/pfre_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pfre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/core/pfre_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pfre_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfre_pkg::t_div_req i_req,
    output pfre_pkg::t_div_rsp o_rsp
);
    import pfre_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [CUM_W-1:0]      r_rem;
    logic [ACC_W-1:0]      r_quo;
    logic [CUM_W:0]        rem_sh;
    logic [CUM_W:0]        diff;
    logic                  ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[ACC_W-1]};
        diff = rem_sh - {1'b0, i_req.divisor};
        ge = rem_sh >= {1'b0, i_req.divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_STEP_W'(ACC_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= ge ? diff[CUM_W-1:0] : rem_sh[CUM_W-1:0];
            r_quo <= {r_quo[ACC_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire
